### sv/lssc_pkg.sv
// shared types, register indexes and constants of the lookahead steer speed controller
package lssc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_TX,
        ST_MUL_TY,
        ST_SHRINK_T,
        ST_MUL_C1,
        ST_MUL_C2,
        ST_MUL_D1,
        ST_MUL_D2,
        ST_SHRINK_CD,
        ST_CORDIC,
        ST_MUL_ST,
        ST_MUL_SP,
        ST_FINISH
    } state_t;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_LOOKAHEAD  = 3'd0;
    localparam reg_idx_t REG_STEER_GAIN = 3'd1;
    localparam reg_idx_t REG_THR_GAIN   = 3'd2;
    localparam reg_idx_t REG_BRK_GAIN   = 3'd3;
    localparam reg_idx_t REG_SLEW_STEP  = 3'd4;
    localparam reg_idx_t REG_HOLD_TICKS = 3'd5;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CD_IN_W  = 30;
    localparam int CD_W     = 34;
    localparam int ANGLE_W  = 28;

    // quarter turn in q24 radians
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 28'sd26353589;

    localparam logic [14:0] FULL_SCALE = 15'd16384;

    function automatic logic signed [ANGLE_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] r;
        case (idx)
            5'd0:    r = 28'sd13176795;
            5'd1:    r = 28'sd7778716;
            5'd2:    r = 28'sd4110060;
            5'd3:    r = 28'sd2086331;
            5'd4:    r = 28'sd1047214;
            5'd5:    r = 28'sd524117;
            5'd6:    r = 28'sd262123;
            5'd7:    r = 28'sd131069;
            5'd8:    r = 28'sd65536;
            5'd9:    r = 28'sd32768;
            5'd10:   r = 28'sd16384;
            5'd11:   r = 28'sd8192;
            5'd12:   r = 28'sd4096;
            5'd13:   r = 28'sd2048;
            5'd14:   r = 28'sd1024;
            5'd15:   r = 28'sd512;
            5'd16:   r = 28'sd256;
            5'd17:   r = 28'sd128;
            5'd18:   r = 28'sd64;
            5'd19:   r = 28'sd32;
            5'd20:   r = 28'sd16;
            5'd21:   r = 28'sd8;
            5'd22:   r = 28'sd4;
            5'd23:   r = 28'sd2;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

### sv/lookahead_steer_speed_controller.sv
// top level of the lookahead steer speed controller: sequencer, registers and datapath
//
// channel | dir | handshake        | payload
// s_      | in  | s_tvalid/tready  | s_tdata positions, headings, speeds; s_tuser restart
// m_      | out | m_tvalid/tready  | m_tdata steering, throttle, brake; m_tuser hand, holding
// cfg_    | in  | cfg_wr_en        | cfg_addr register index, cfg_wr_data value
//
// a request in brake hold goes from the start step straight to the finish step; a
// steering request runs its multiply steps in turn on the single shared multiplier,
// takes one halving step per halving of the target vector and of cross/dot (up to 26
// halvings for POSITION_BITS 24), and waits on the one-step-per-cycle cordic
// reset (aresetn low, synchronous) loads register defaults and clears history
// s_tready is high only while idle; a finished result waits in the output
// register and the next result is not written until it is taken
module lookahead_steer_speed_controller
    import lssc_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int POSITION_BITS = 24,
    localparam int S_TDATA_W    = ((4 * POSITION_BITS + 97 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata low to high: follower_x, follower_y, follower_head_x, follower_head_y,
    // leader_x, leader_y, leader_head_x, leader_head_y, desired_speed, forward_speed
    input  logic [S_TDATA_W-1:0] s_tdata,
    // tuser: restart
    input  logic                 s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata low to high: steering, throttle, brake
    output logic [47:0]          m_tdata,
    // tuser low to high: handbrake, holding
    output logic [1:0]           m_tuser,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_addr,
    input  logic [15:0]          cfg_wr_data
);

    localparam int PB = POSITION_BITS;
    // target vector width: position difference in q14 plus lookahead term
    localparam int TW = PB + 16;
    localparam int CW = 48;
    localparam logic signed [TW-1:0] T_LIM = TW'(64'sd1 <<< 30);
    localparam logic signed [CW-1:0] C_LIM = CW'(64'sd1 <<< 29);

    // field offsets inside s_tdata
    localparam int O_FY  = PB;
    localparam int O_FHX = 2 * PB;
    localparam int O_FHY = 2 * PB + 16;
    localparam int O_LX  = 2 * PB + 32;
    localparam int O_LY  = 3 * PB + 32;
    localparam int O_LHX = 4 * PB + 32;
    localparam int O_LHY = 4 * PB + 48;
    localparam int O_DES = 4 * PB + 64;
    localparam int O_FWD = 4 * PB + 80;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] la_reg, sg_reg, tg_reg, bg_reg, hold_ticks_reg;
    logic [14:0] slew_reg;

    // latched request
    logic signed [PB-1:0] fx_reg, fy_reg, lx_reg, ly_reg;
    logic signed [15:0]   fhx_reg, fhy_reg, lhx_reg, lhy_reg;
    logic [15:0]          des_reg;
    logic signed [16:0]   fwd_reg;

    // working registers
    logic signed [TW-1:0]      tx_reg, tx_next, ty_reg, ty_next;
    logic signed [CW-1:0]      cr_reg, cr_next, dt_reg, dt_next;
    logic signed [ANGLE_W-1:0] yaw_reg, yaw_next;
    logic signed [15:0]        st_tgt_reg, st_tgt_next;
    logic [14:0]               th_tgt_reg, th_tgt_next, br_tgt_reg, br_tgt_next;
    logic                      hold_reg, hold_next;

    // history
    logic signed [15:0] last_st_reg, last_st_next;
    logic [14:0]        last_th_reg, last_th_next, last_br_reg, last_br_next;
    logic [15:0]        age_reg, age_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      cd_start, cd_done;
    logic signed [ANGLE_W-1:0] cd_z;

    logic signed [TW-1:0]      lx_e, fx_e, ly_e, fy_e;
    logic signed [ANGLE_W-1:0] yaw_mag;
    logic signed [17:0]        fwd_e, spd, err, err_mag;
    logic                      err_neg, big_t, big_c;
    logic signed [MUL_P_W-1:0] rnd_st, rnd_sp;
    logic [14:0]               c_st, c_sp;
    logic signed [17:0]        sl_st, sl_th, sl_br;
    logic                      accept;

    function automatic logic signed [TW-1:0] half_t(input logic signed [TW-1:0] v);
        // halve toward zero
        return (v + $signed({{(TW-1){1'b0}}, v[TW-1]})) >>> 1;
    endfunction

    function automatic logic signed [CW-1:0] half_c(input logic signed [CW-1:0] v);
        return (v + $signed({{(CW-1){1'b0}}, v[CW-1]})) >>> 1;
    endfunction

    function automatic logic signed [17:0] slew(input logic signed [17:0] prev,
                                                input logic signed [17:0] tgt,
                                                input logic [14:0] s);
        logic signed [17:0] hi, lo, r;
        hi = prev + $signed({3'b0, s});
        lo = prev - $signed({3'b0, s});
        if (tgt > hi) begin
            r = hi;
        end else if (tgt < lo) begin
            r = lo;
        end else begin
            r = tgt;
        end
        return r;
    endfunction

    lssc_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (prod)
    );

    lssc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cd_start),
        .y_in    (cr_reg[CD_IN_W-1:0]),
        .x_in    (dt_reg[CD_IN_W-1:0]),
        .done    (cd_done),
        .z_out   (cd_z)
    );

    assign accept = s_tvalid && s_tready;

    // datapath helpers
    always_comb begin
        lx_e = TW'(lx_reg);
        fx_e = TW'(fx_reg);
        ly_e = TW'(ly_reg);
        fy_e = TW'(fy_reg);
        yaw_mag = yaw_reg[ANGLE_W-1] ? -yaw_reg : yaw_reg;
        fwd_e = 18'(fwd_reg);
        spd = fwd_e[17] ? -fwd_e : fwd_e;
        err = $signed({2'b0, des_reg}) - spd;
        err_neg = err[17];
        err_mag = err_neg ? -err : err;
        big_t = (tx_reg >= T_LIM) || (tx_reg <= -T_LIM) ||
                (ty_reg >= T_LIM) || (ty_reg <= -T_LIM);
        big_c = (cr_reg >= C_LIM) || (cr_reg <= -C_LIM) ||
                (dt_reg >= C_LIM) || (dt_reg <= -C_LIM);
        // round half away from zero on the magnitude, then clamp to full scale
        rnd_st = (prod + MUL_P_W'(64'sd1 <<< 21)) >>> 22;
        rnd_sp = (prod + MUL_P_W'(64'sd1 <<< 9)) >>> 10;
        c_st = (rnd_st > $signed(MUL_P_W'(FULL_SCALE))) ? FULL_SCALE : rnd_st[14:0];
        c_sp = (rnd_sp > $signed(MUL_P_W'(FULL_SCALE))) ? FULL_SCALE : rnd_sp[14:0];
        sl_st = slew(18'(last_st_reg), 18'(st_tgt_reg), slew_reg);
        sl_th = slew($signed({3'b0, last_th_reg}), $signed({3'b0, th_tgt_reg}), slew_reg);
        sl_br = slew($signed({3'b0, last_br_reg}), $signed({3'b0, br_tgt_reg}), slew_reg);
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_TX: begin
                mul_a = $signed({16'b0, la_reg});
                mul_b = MUL_B_W'(lhx_reg);
            end
            ST_MUL_TY: begin
                mul_a = $signed({16'b0, la_reg});
                mul_b = MUL_B_W'(lhy_reg);
            end
            ST_MUL_C1: begin
                mul_a = ty_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(fhx_reg);
            end
            ST_MUL_C2: begin
                mul_a = tx_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(fhy_reg);
            end
            ST_MUL_D1: begin
                mul_a = tx_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(fhx_reg);
            end
            ST_MUL_D2: begin
                mul_a = ty_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(fhy_reg);
            end
            ST_MUL_ST: begin
                mul_a = MUL_A_W'(yaw_mag);
                mul_b = $signed({1'b0, sg_reg});
            end
            ST_MUL_SP: begin
                mul_a = MUL_A_W'(err_mag);
                mul_b = $signed({1'b0, err_neg ? bg_reg : tg_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        cr_next      = cr_reg;
        dt_next      = dt_reg;
        yaw_next     = yaw_reg;
        st_tgt_next  = st_tgt_reg;
        th_tgt_next  = th_tgt_reg;
        br_tgt_next  = br_tgt_reg;
        hold_next    = hold_reg;
        last_st_next = last_st_reg;
        last_th_next = last_th_reg;
        last_br_next = last_br_reg;
        age_next     = age_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        cd_start     = 1'b0;
        s_tready     = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // restart clears history before the hold check
                    if (s_tuser) begin
                        age_next     = '0;
                        last_st_next = '0;
                        last_th_next = '0;
                        last_br_next = '0;
                    end
                    state_next = ST_START;
                end
            end
            ST_START: begin
                hold_next  = (age_reg < hold_ticks_reg);
                state_next = (age_reg < hold_ticks_reg) ? ST_FINISH : ST_MUL_TX;
            end
            ST_MUL_TX: begin
                tx_next    = ((lx_e - fx_e) <<< 14) + TW'(prod);
                state_next = ST_MUL_TY;
            end
            ST_MUL_TY: begin
                ty_next    = ((ly_e - fy_e) <<< 14) + TW'(prod);
                state_next = ST_SHRINK_T;
            end
            ST_SHRINK_T: begin
                if (big_t) begin
                    tx_next = half_t(tx_reg);
                    ty_next = half_t(ty_reg);
                end else begin
                    state_next = ST_MUL_C1;
                end
            end
            ST_MUL_C1: begin
                cr_next    = CW'(prod);
                state_next = ST_MUL_C2;
            end
            ST_MUL_C2: begin
                cr_next    = cr_reg - CW'(prod);
                state_next = ST_MUL_D1;
            end
            ST_MUL_D1: begin
                dt_next    = CW'(prod);
                state_next = ST_MUL_D2;
            end
            ST_MUL_D2: begin
                dt_next    = dt_reg + CW'(prod);
                state_next = ST_SHRINK_CD;
            end
            ST_SHRINK_CD: begin
                if (big_c) begin
                    cr_next = half_c(cr_reg);
                    dt_next = half_c(dt_reg);
                end else if (cr_reg == '0 && dt_reg == '0) begin
                    // no direction to aim at
                    yaw_next   = '0;
                    state_next = ST_MUL_ST;
                end else begin
                    cd_start   = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (cd_done) begin
                    yaw_next   = cd_z;
                    state_next = ST_MUL_ST;
                end
            end
            ST_MUL_ST: begin
                st_tgt_next = yaw_reg[ANGLE_W-1] ? -$signed({1'b0, c_st})
                                                 : $signed({1'b0, c_st});
                state_next  = ST_MUL_SP;
            end
            ST_MUL_SP: begin
                if (err_neg) begin
                    th_tgt_next = '0;
                    br_tgt_next = c_sp;
                end else begin
                    th_tgt_next = c_sp;
                    br_tgt_next = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // write the result only once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    if (hold_reg) begin
                        m_data_next = {2'b00, FULL_SCALE, 15'd0, 16'd0};
                        m_user_next = 2'b11;
                        if (age_reg != 16'hFFFF) begin
                            age_next = age_reg + 16'd1;
                        end
                    end else begin
                        last_st_next = sl_st[15:0];
                        last_th_next = sl_th[14:0];
                        last_br_next = sl_br[14:0];
                        m_data_next  = {2'b00, sl_br[14:0], sl_th[14:0], sl_st[15:0]};
                        m_user_next  = 2'b00;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            la_reg         <= 16'd1200;
            sg_reg         <= 16'd4096;
            tg_reg         <= 16'd16777;
            bg_reg         <= 16'd25166;
            slew_reg       <= 15'd1365;
            hold_ticks_reg <= 16'd30;
            last_st_reg    <= '0;
            last_th_reg    <= '0;
            last_br_reg    <= '0;
            age_reg        <= '0;
            m_valid_reg    <= 1'b0;
            hold_reg       <= 1'b0;
        end else begin
            state_reg   <= state_next;
            last_st_reg <= last_st_next;
            last_th_reg <= last_th_next;
            last_br_reg <= last_br_next;
            age_reg     <= age_next;
            m_valid_reg <= m_valid_next;
            hold_reg    <= hold_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LOOKAHEAD:  la_reg         <= cfg_wr_data;
                    REG_STEER_GAIN: sg_reg         <= cfg_wr_data;
                    REG_THR_GAIN:   tg_reg         <= cfg_wr_data;
                    REG_BRK_GAIN:   bg_reg         <= cfg_wr_data;
                    REG_SLEW_STEP:  slew_reg       <= cfg_wr_data[14:0];
                    REG_HOLD_TICKS: hold_ticks_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
        if (accept) begin
            fx_reg  <= s_tdata[PB-1:0];
            fy_reg  <= s_tdata[O_FY +: PB];
            fhx_reg <= s_tdata[O_FHX +: 16];
            fhy_reg <= s_tdata[O_FHY +: 16];
            lx_reg  <= s_tdata[O_LX +: PB];
            ly_reg  <= s_tdata[O_LY +: PB];
            lhx_reg <= s_tdata[O_LHX +: 16];
            lhy_reg <= s_tdata[O_LHY +: 16];
            des_reg <= s_tdata[O_DES +: 16];
            fwd_reg <= s_tdata[O_FWD +: 17];
        end
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        cr_reg     <= cr_next;
        dt_reg     <= dt_next;
        yaw_reg    <= yaw_next;
        st_tgt_reg <= st_tgt_next;
        th_tgt_reg <= th_tgt_next;
        br_tgt_reg <= br_tgt_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // cordic finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cd_done |-> state_reg == ST_CORDIC)
        else $error("cordic done outside its wait state");

    // a new result appears only from the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request taken while busy");

    // hold results carry full brake, handbrake and no throttle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg[1]) |->
            (m_user_reg[0] && m_data_reg[47:31] == {2'b00, FULL_SCALE} &&
             m_data_reg[30:16] == 15'd0))
        else $error("hold result malformed");

endmodule

### sv/lssc_mul.sv
// shared signed multiplier used for every product of the controller
module lssc_mul
    import lssc_pkg::*;
(
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] p
);

    assign p = MUL_P_W'(a) * MUL_P_W'(b);

endmodule

### sv/lssc_cordic.sv
// iterative cordic vectoring unit, atan2 in q24 radians, one step per cycle
module lssc_cordic
    import lssc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [CD_IN_W-1:0] y_in,
    input  logic signed [CD_IN_W-1:0] x_in,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] z_out
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [CD_W-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;

    logic signed [CD_W-1:0]    xe, ye, dx, dy;
    logic signed [ANGLE_W-1:0] ang;

    always_comb begin
        xe = CD_W'(x_in);
        ye = CD_W'(y_in);
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        ang = atan_q24(5'(cnt_reg));
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // left half plane: rotate by a quarter turn first
            if (xe < 0) begin
                if (ye >= 0) begin
                    x_next = ye;
                    y_next = -xe;
                    z_next = QUARTER_TURN;
                end else begin
                    x_next = -ye;
                    y_next = xe;
                    z_next = -QUARTER_TURN;
                end
            end else begin
                x_next = xe;
                y_next = ye;
                z_next = '0;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end else begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign z_out = z_reg;

endmodule

### sim/tb_lookahead_steer_speed_controller.sv
// self-checking testbench for the lookahead steer speed controller
module tb_lookahead_steer_speed_controller;
    import lssc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W    = 24;
    localparam int S_W      = 200;
    localparam int WDOG_MAX = 5000;

    // one control request and one command result
    typedef struct {
        logic signed [23:0] fx, fy, lx, ly;
        logic signed [15:0] fhx, fhy, lhx, lhy;
        logic [15:0]        desired;
        logic signed [16:0] fwd;
        logic               restart;
    } steer_req_t;

    typedef struct {
        logic signed [15:0] steering;
        logic [14:0]        throttle;
        logic [14:0]        brake;
        logic               handbrake;
        logic               holding;
    } steer_cmd_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           s_tuser = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [47:0]    m_tdata;
    logic [1:0]     m_tuser;
    logic           cfg_wr_en = 1'b0;
    logic [2:0]     cfg_addr = '0;
    logic [15:0]    cfg_wr_data = '0;

    lookahead_steer_speed_controller #(.CORDIC_STEPS(16), .POSITION_BITS(POS_W)) DUT (.*);

    always #5 aclk = ~aclk;

    // shadow copy of the control registers and history
    longint unsigned lookahead_cm, steer_gain, throttle_gain, brake_gain, slew_step, hold_ticks;
    longint          prev_steer, prev_throttle, prev_brake;
    longint unsigned age_ticks;

    steer_req_t steer_reqs[$];     // requests not yet offered
    steer_cmd_t cmd_expect[$];     // predicted commands in order
    steer_req_t cur_req;
    logic       req_taken = 1'b0;
    int         send_gap = 0, recv_gap = 0;
    bit         idle_on = 1'b1;
    int         mismatches = 0, cmds_seen = 0, reqs_sent = 0, holds_seen = 0;
    int         wdog = 0;
    bit         run_done = 1'b0;

    function automatic longint iabs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // vectoring cordic, angle in q24 radians
    function automatic longint yaw_atan2(longint y, longint x);
        longint z = 0, t, dx, dy;
        longint atan_tab[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                                 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                                 1024, 512};
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 26353589;
            end else begin
                x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    // |v| * gain >> sh, rounded half away from zero, clamped to full scale
    function automatic longint scale_round(longint v, longint gain, int sh);
        longint m;
        m = iabs(v) * gain;
        m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
        if (m > 16384) m = 16384;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint slew_limit(longint prev, longint tgt);
        longint s = longint'(slew_step);
        if (tgt > prev + s) return prev + s;
        if (tgt < prev - s) return prev - s;
        return tgt;
    endfunction

    // next command for an accepted request, updates the shadow history
    function automatic steer_cmd_t steer_command(steer_req_t r);
        steer_cmd_t c;
        longint tx, ty, cr, dt, yaw, err, st, th, br;
        if (r.restart) begin
            age_ticks = 0; prev_steer = 0; prev_throttle = 0; prev_brake = 0;
        end
        if (age_ticks < hold_ticks) begin
            c = '{16'sd0, 15'd0, FULL_SCALE, 1'b1, 1'b1};
            if (age_ticks < 65535) age_ticks++;
            return c;
        end
        tx = (longint'(r.lx) - longint'(r.fx)) * 16384 + longint'(r.lhx) * longint'(lookahead_cm);
        ty = (longint'(r.ly) - longint'(r.fy)) * 16384 + longint'(r.lhy) * longint'(lookahead_cm);
        while (iabs(tx) >= (longint'(1) <<< 30) || iabs(ty) >= (longint'(1) <<< 30)) begin
            tx = tx / 2; ty = ty / 2;
        end
        cr = longint'(r.fhx) * ty - longint'(r.fhy) * tx;
        dt = longint'(r.fhx) * tx + longint'(r.fhy) * ty;
        while (iabs(cr) >= (longint'(1) <<< 29) || iabs(dt) >= (longint'(1) <<< 29)) begin
            cr = cr / 2; dt = dt / 2;
        end
        yaw = (cr == 0 && dt == 0) ? 0 : yaw_atan2(cr, dt);
        st  = scale_round(yaw, longint'(steer_gain), 22);
        err = longint'(r.desired) - iabs(longint'(r.fwd));
        th  = 0;
        br  = 0;
        if (err >= 0) th = scale_round(err, longint'(throttle_gain), 10);
        else          br = scale_round(-err, longint'(brake_gain), 10);
        prev_steer    = slew_limit(prev_steer, st);
        prev_throttle = slew_limit(prev_throttle, th);
        prev_brake    = slew_limit(prev_brake, br);
        c.steering  = prev_steer[15:0];
        c.throttle  = prev_throttle[14:0];
        c.brake     = prev_brake[14:0];
        c.handbrake = 1'b0;
        c.holding   = 1'b0;
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("mismatch on command %0d: %s got %0d want %0d", cmds_seen, what, got, want);
    endtask

    // request driver, changes on the falling edge
    always @(negedge aclk) begin
        if (!s_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (steer_reqs.size() > 0) begin
                cur_req = steer_reqs.pop_front();
                s_tdata <= {7'd0, cur_req.fwd, cur_req.desired, cur_req.lhy, cur_req.lhx,
                            cur_req.ly, cur_req.lx, cur_req.fhy, cur_req.fhx,
                            cur_req.fy, cur_req.fx};
                s_tuser  <= cur_req.restart;
                s_tvalid <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // result side back-pressure in bursts
        if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn;
        end
    end

    // request and command monitor, samples on the rising edge
    always @(posedge aclk) begin
        steer_cmd_t want;
        bit moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            cmd_expect.push_back(steer_command(cur_req));
            req_taken = 1'b1;
            reqs_sent++;
            moved = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1'b1;
            if (cmd_expect.size() == 0) begin
                report_mismatch("command with nothing pending, steering", m_tdata[15:0], 0);
            end else begin
                want = cmd_expect.pop_front();
                if (m_tdata[15:0] !== want.steering)
                    report_mismatch("steering", $signed(m_tdata[15:0]), want.steering);
                if (m_tdata[30:16] !== want.throttle)
                    report_mismatch("throttle", m_tdata[30:16], want.throttle);
                if (m_tdata[45:31] !== want.brake)
                    report_mismatch("brake", m_tdata[45:31], want.brake);
                if (m_tuser[0] !== want.handbrake)
                    report_mismatch("handbrake", m_tuser[0], want.handbrake);
                if (m_tuser[1] !== want.holding)
                    report_mismatch("holding", m_tuser[1], want.holding);
                if (want.holding) holds_seen++;
            end
            cmds_seen++;
        end
        // watchdog on cycles with no handshake at all
        if (!aresetn || moved || run_done) begin
            wdog = 0;
        end else if (++wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d commands pending", cmd_expect.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_LOOKAHEAD:  lookahead_cm  = val;
            REG_STEER_GAIN: steer_gain    = val;
            REG_THR_GAIN:   throttle_gain = val;
            REG_BRK_GAIN:   brake_gain    = val;
            REG_SLEW_STEP:  slew_step     = val[14:0];
            REG_HOLD_TICKS: hold_ticks    = val;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] la, logic [15:0] sg, logic [15:0] tg,
                             logic [15:0] bg, logic [15:0] ss, logic [15:0] ht);
        write_reg(REG_LOOKAHEAD, la);
        write_reg(REG_STEER_GAIN, sg);
        write_reg(REG_THR_GAIN, tg);
        write_reg(REG_BRK_GAIN, bg);
        write_reg(REG_SLEW_STEP, ss);
        write_reg(REG_HOLD_TICKS, ht);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender holds off until every pending command has come back
    task automatic drain();
        while (steer_reqs.size() > 0 || s_tvalid || cmd_expect.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic steer_req_t make_req(int unsigned fx, int unsigned fy, int fhx, int fhy,
                                            int unsigned lx, int unsigned ly, int lhx, int lhy,
                                            int desired, int fwd, bit rs);
        steer_req_t r;
        r.fx = fx[23:0]; r.fy = fy[23:0]; r.lx = lx[23:0]; r.ly = ly[23:0];
        r.fhx = fhx[15:0]; r.fhy = fhy[15:0]; r.lhx = lhx[15:0]; r.lhy = lhy[15:0];
        r.desired = desired[15:0]; r.fwd = fwd[16:0]; r.restart = rs;
        return r;
    endfunction

    // heading mostly within plus or minus unit length, sometimes any 16-bit pattern
    function automatic int rand_head();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535) - 32768;
            1:       return 16384;
            2:       return -16384;
            3:       return 0;
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    function automatic steer_req_t rand_req();
        steer_req_t r;
        int unsigned fx, fy;
        int fwd;
        fx = $urandom();
        fy = $urandom();
        if ($urandom_range(0, 3) == 0) begin
            // far apart: any positions at all
            r = make_req(fx, fy, rand_head(), rand_head(), $urandom(), $urandom,
                         rand_head(), rand_head(), 0, 0, 0);
        end else begin
            // leader a few meters to tens of meters from the follower
            r = make_req(fx, fy, rand_head(), rand_head(),
                         fx + $urandom_range(0, 8000) - 4000, fy + $urandom_range(0, 8000) - 4000,
                         rand_head(), rand_head(), 0, 0, 0);
        end
        r.desired = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
        fwd = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 6000) - 3000;
        r.fwd = fwd[16:0];
        r.restart = ($urandom_range(0, 60) == 0);
        return r;
    endfunction

    initial begin
        int phases;
        lookahead_cm = 1200; steer_gain = 4096; throttle_gain = 16777; brake_gain = 25166;
        slew_step = 1365; hold_ticks = 30;
        prev_steer = 0; prev_throttle = 0; prev_brake = 0; age_ticks = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: short brake hold, then extremes with a fast slew
        write_all(16'd1200, 16'd4096, 16'd16777, 16'd25166, 16'd16384, 16'd3);
        steer_reqs.push_back(make_req(0, 0, 16384, 0, 100, 0, 16384, 0, 500, 0, 1));
        repeat (3) steer_reqs.push_back(make_req(0, 0, 16384, 0, 100, 0, 16384, 0, 500, 0, 0));
        // zero heading gives a zero vector
        steer_reqs.push_back(make_req(0, 0, 0, 0, 500, 500, 16384, 0, 100, 100, 0));
        // leader behind: negative dot, both sides
        steer_reqs.push_back(make_req(0, 0, 16384, 0, -5000, 10, -16384, 0, 0, -65536, 0));
        steer_reqs.push_back(make_req(0, 0, 16384, 0, -5000, -10, -16384, 0, 65535, 65535, 0));
        steer_reqs.push_back(make_req(0, 0, 0, -16384, 3000, 0, 0, 16384, 65535, -65536, 0));
        // position extremes force the halving of the target
        steer_reqs.push_back(make_req(32'h800000, 32'h800000, 16384, 16384, 32'h7fffff,
                                      32'h7fffff, 16384, 16384, 0, 65535, 0));
        steer_reqs.push_back(make_req(32'h7fffff, 32'h7fffff, -16384, -16384, 32'h800000,
                                      32'h800000, -16384, 16384, 65535, 0, 0));
        // out of range heading patterns
        steer_reqs.push_back(make_req(0, 0, -32768, 32767, 100, -100, 32767, -32768, 1, -1, 0));
        steer_reqs.push_back(make_req(-1, 1, 11585, 11585, 1, -1, -11585, 11585, 2000, 2000, 0));
        // restart in the middle, then a hold that lasts three requests
        steer_reqs.push_back(make_req(0, 0, 16384, 0, 100, 5, 16384, 0, 500, 0, 1));
        repeat (4) steer_reqs.push_back(make_req(0, 0, 16384, 0, 100, 5, 16384, 0, 800, 50, 0));
        drain();

        // random phases over a spread of register settings, extremes first
        phases = 8;
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                1: write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'd0);
                2: write_all(16'd1200, 16'd4096, 16'd16777, 16'd25166, 16'd1365, 16'hffff);
                3: write_all(16'd1200, 16'd4096, 16'd16777, 16'd25166, 16'hffff, 16'd5);
                default: write_all(16'($urandom()), 16'($urandom_range(0, 20000)),
                                   16'($urandom()), 16'($urandom()),
                                   16'($urandom_range(0, 20000)), 16'($urandom_range(0, 40)));
            endcase
            if (p == phases - 1) idle_on = 1'b0;
            // first request of a phase restarts so the hold setting shows
            steer_reqs.push_back(make_req(0, 0, 16384, 0, 10, 10, 16384, 0, 0, 0, 1));
            repeat ((p == 2) ? 60 : 280) steer_reqs.push_back(rand_req());
            drain();
        end

        run_done = 1'b1;
        $display("covered %0d requests, %0d commands (%0d in brake hold) over %0d settings",
                 reqs_sent, cmds_seen, holds_seen, phases + 1);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
